// File: hw/rtl/mmsc_pkg.sv
package mmsc_pkg;

  localparam int XLEN        = 32;
  localparam int RF_DEPTH    = 32;
  localparam int RF_AW       = 5;
  localparam int DATA_WORDS  = 1024;
  localparam int DM_AW       = 10;
  localparam int OUT_TDATA_W = 112;
  localparam int OUT_TUSER_W = 4;

  localparam logic [5:0] OP_ADDI  = 6'd49;
  localparam logic [5:0] OP_LW    = 6'd17;
  localparam logic [5:0] OP_SW    = 6'd18;
  localparam logic [5:0] OP_BEQ   = 6'd10;
  localparam logic [5:0] OP_JR    = 6'd37;
  localparam logic [5:0] OP_JAL   = 6'd8;
  localparam logic [5:0] OP_RTYPE = 6'd32;

  localparam logic [5:0] FN_ADD = 6'd32;
  localparam logic [5:0] FN_AND = 6'd36;
  localparam logic [5:0] FN_SUB = 6'd40;
  localparam logic [5:0] FN_SGT = 6'd48;

  localparam logic [RF_AW-1:0] LINK_REG = 5'd31;

  typedef struct packed {
    logic             en;
    logic [RF_AW-1:0] idx;
    logic [XLEN-1:0]  val;
  } fwd_t;

  typedef struct packed {
    logic [XLEN-1:0]  next_pc;
    logic             reg_written;
    logic [RF_AW-1:0] reg_index;
    logic [XLEN-1:0]  reg_value;
    logic             mem_written;
    logic [DM_AW-1:0] mem_address;
    logic [XLEN-1:0]  alu_value;
    logic             branch_taken;
    logic             bad_instruction;
  } result_t;

  typedef struct packed {
    result_t         res;
    logic            is_load;
    logic [XLEN-1:0] store_data;
  } exec_t;

endpackage

// File: hw/rtl/mmsc_ram.sv
module mmsc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/mmsc_exec.sv
module mmsc_exec import mmsc_pkg::*; (
  input  logic [XLEN-1:0] instr,
  input  logic [XLEN-1:0] pc,
  input  logic [XLEN-1:0] rf_a,
  input  logic [XLEN-1:0] rf_b,
  input  fwd_t            fwd_near,
  input  fwd_t            fwd_far,
  output exec_t           ex
);

  logic [5:0]       op;
  logic [5:0]       fn;
  logic [RF_AW-1:0] rs;
  logic [RF_AW-1:0] rt;
  logic [RF_AW-1:0] rd;
  logic [XLEN-1:0]  imm;
  logic [XLEN-1:0]  a;
  logic [XLEN-1:0]  b;
  logic [XLEN-1:0]  pc1;
  logic [XLEN-1:0]  sum_imm;

  assign op  = instr[31:26];
  assign rs  = instr[25:21];
  assign rt  = instr[20:16];
  assign rd  = instr[15:11];
  assign fn  = instr[5:0];
  assign imm = {{16{instr[15]}}, instr[15:0]};

  // Results of the two instructions ahead are not yet in the register file read.
  always_comb begin
    if (fwd_near.en && fwd_near.idx == rs) begin
      a = fwd_near.val;
    end else if (fwd_far.en && fwd_far.idx == rs) begin
      a = fwd_far.val;
    end else begin
      a = rf_a;
    end
    if (fwd_near.en && fwd_near.idx == rt) begin
      b = fwd_near.val;
    end else if (fwd_far.en && fwd_far.idx == rt) begin
      b = fwd_far.val;
    end else begin
      b = rf_b;
    end
  end

  assign pc1     = pc + 32'd1;
  assign sum_imm = a + imm;

  always_comb begin
    ex                     = '0;
    ex.res.next_pc         = pc1;
    ex.store_data          = b;
    case (op)
      OP_ADDI: begin
        ex.res.alu_value   = sum_imm;
        ex.res.reg_written = 1'b1;
        ex.res.reg_index   = rt;
        ex.res.reg_value   = sum_imm;
      end
      OP_LW: begin
        ex.res.alu_value   = sum_imm;
        ex.res.mem_address = sum_imm[DM_AW-1:0];
        ex.res.reg_written = 1'b1;
        ex.res.reg_index   = rt;
        ex.is_load         = 1'b1;
      end
      OP_SW: begin
        ex.res.alu_value   = sum_imm;
        ex.res.mem_address = sum_imm[DM_AW-1:0];
        ex.res.mem_written = 1'b1;
      end
      OP_BEQ: begin
        ex.res.alu_value = a - b;
        if (a == b) begin
          ex.res.next_pc      = pc + imm;
          ex.res.branch_taken = 1'b1;
        end
      end
      OP_JR: begin
        ex.res.next_pc      = a;
        ex.res.branch_taken = 1'b1;
      end
      OP_JAL: begin
        ex.res.reg_written  = 1'b1;
        ex.res.reg_index    = LINK_REG;
        ex.res.reg_value    = pc1;
        ex.res.next_pc      = imm;
        ex.res.branch_taken = 1'b1;
      end
      OP_RTYPE: begin
        ex.res.reg_written = 1'b1;
        ex.res.reg_index   = rd;
        case (fn)
          FN_ADD: ex.res.alu_value = a + b;
          FN_AND: ex.res.alu_value = a & b;
          FN_SUB: ex.res.alu_value = a - b;
          FN_SGT: ex.res.alu_value = {31'd0, $signed(a) > $signed(b)};
          default: begin
            ex.res.bad_instruction = 1'b1;
            ex.res.reg_written     = 1'b0;
            ex.res.reg_index       = '0;
          end
        endcase
        ex.res.reg_value = ex.res.alu_value;
      end
      default: begin
        ex.res.bad_instruction = 1'b1;
      end
    endcase
  end

endmodule

// File: hw/rtl/mini_mips_single_cycle_core_top.sv
// This core executes one instruction beat per clock, back to back, with no stall for any
// dependence: register results, including load data, reach the next instructions through
// forwarding paths. An instruction beat passes through the s1, s2 and output registers on
// its way to the outputs, the register file and data memory reads each being registered.
// The program counter starts at zero and advances only with executed instructions. After
// reset the core clears its data memory and register file, one word per cycle over all
// 1024 data words, and holds in_tready low until that pass ends. Beyond that pass, only a
// stall on the result side (out_tready low with a beat pending) holds up the input.
module mini_mips_single_cycle_core_top import mmsc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // Bits from low: instr_word[31:0].
  input  logic [XLEN-1:0]        in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // Bits from low: next_pc[31:0], reg_index[36:32], reg_value[68:37],
  // mem_address[78:69], alu_value[110:79], zero pad[111].
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // Bits from low: reg_written, mem_written, branch_taken, bad_instruction.
  output logic [OUT_TUSER_W-1:0] out_tuser
);

  logic             clr_active_r;
  logic             clr_active_nxt;
  logic [DM_AW-1:0] clr_addr_r;
  logic [DM_AW-1:0] clr_addr_nxt;
  logic             advance;
  logic             in_fire;
  logic             s1_valid_r;
  logic [XLEN-1:0]  s1_instr_r;
  logic             s2_valid_r;
  exec_t            s2_r;
  logic             out_valid_r;
  result_t          out_r;
  logic [XLEN-1:0]  pc_r;
  logic [XLEN-1:0]  pc_nxt;
  exec_t            ex;
  result_t          s2_res;
  logic [XLEN-1:0]  rf_a;
  logic [XLEN-1:0]  rf_b;
  logic [XLEN-1:0]  dm_rdata;
  fwd_t             fwd_near;
  fwd_t             fwd_far;
  logic             rf_we;
  logic [RF_AW-1:0] rf_waddr;
  logic [XLEN-1:0]  rf_wdata;
  logic             dm_we;
  logic [DM_AW-1:0] dm_waddr;
  logic [XLEN-1:0]  dm_wdata;

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = advance && !clr_active_r;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    clr_active_nxt = clr_active_r;
    clr_addr_nxt   = clr_addr_r;
    if (clr_active_r) begin
      clr_addr_nxt = clr_addr_r + DM_AW'(1);
      if (&clr_addr_r) begin
        clr_active_nxt = 1'b0;
      end
    end
  end

  assign pc_nxt = (advance && s1_valid_r) ? ex.res.next_pc : pc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
      pc_r         <= '0;
      s1_valid_r   <= 1'b0;
      s2_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      clr_active_r <= clr_active_nxt;
      clr_addr_r   <= clr_addr_nxt;
      pc_r         <= pc_nxt;
      if (advance) begin
        s1_valid_r  <= in_fire;
        s2_valid_r  <= s1_valid_r;
        out_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_instr_r <= in_tdata;
      s2_r       <= ex;
      out_r      <= s2_res;
    end
  end

  always_comb begin
    s2_res = s2_r.res;
    if (s2_r.is_load) begin
      s2_res.reg_value = dm_rdata;
    end
  end

  assign fwd_near.en  = s2_valid_r && s2_res.reg_written;
  assign fwd_near.idx = s2_res.reg_index;
  assign fwd_near.val = s2_res.reg_value;
  assign fwd_far.en   = out_valid_r && out_r.reg_written;
  assign fwd_far.idx  = out_r.reg_index;
  assign fwd_far.val  = out_r.reg_value;

  mmsc_exec u_exec (
    .instr    (s1_instr_r),
    .pc       (pc_r),
    .rf_a     (rf_a),
    .rf_b     (rf_b),
    .fwd_near (fwd_near),
    .fwd_far  (fwd_far),
    .ex       (ex)
  );

  assign rf_we    = clr_active_r || (advance && fwd_near.en);
  assign rf_waddr = clr_active_r ? clr_addr_r[RF_AW-1:0] : s2_res.reg_index;
  assign rf_wdata = clr_active_r ? '0 : s2_res.reg_value;

  mmsc_ram #(.WIDTH(XLEN), .DEPTH(RF_DEPTH)) u_rf_a (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .re    (advance),
    .raddr (in_tdata[25:21]),
    .rdata (rf_a)
  );

  mmsc_ram #(.WIDTH(XLEN), .DEPTH(RF_DEPTH)) u_rf_b (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .re    (advance),
    .raddr (in_tdata[20:16]),
    .rdata (rf_b)
  );

  assign dm_we    = clr_active_r || (advance && s1_valid_r && ex.res.mem_written);
  assign dm_waddr = clr_active_r ? clr_addr_r : ex.res.mem_address;
  assign dm_wdata = clr_active_r ? '0 : ex.store_data;

  mmsc_ram #(.WIDTH(XLEN), .DEPTH(DATA_WORDS)) u_dmem (
    .clk   (clk),
    .we    (dm_we),
    .waddr (dm_waddr),
    .wdata (dm_wdata),
    .re    (advance),
    .raddr (ex.res.mem_address),
    .rdata (dm_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_r.alu_value, out_r.mem_address, out_r.reg_value,
                       out_r.reg_index, out_r.next_pc};
  assign out_tuser  = {out_r.bad_instruction, out_r.branch_taken, out_r.mem_written,
                       out_r.reg_written};

endmodule

// File: hw/rtl/mmsc_checker.sv
module mmsc_checker import mmsc_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [OUT_TUSER_W-1:0] out_tuser
);

  // The memory clearing pass keeps the input closed right after reset.
  a_clear_closes_input: assert property (@(posedge clk)
    !rst_n |=> !in_tready && !out_tvalid)
    else $error("input open or result pending right after reset");

  a_bad_is_noop: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[3] |-> !out_tuser[0] && !out_tuser[1] && !out_tuser[2])
    else $error("bad instruction beat shows a side effect");

  a_store_no_reg: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> !out_tuser[0] && !out_tuser[2])
    else $error("store beat also writes a register or branches");

  a_idle_link: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[36:32] == 5'd0 && out_tdata[68:37] == 32'd0)
    else $error("register fields nonzero without a register write");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result beat changed");

endmodule

bind mini_mips_single_cycle_core_top mmsc_checker u_mmsc_checker (.*);
